@@ hw/rtl/mcdp_pkg.sv @@
// Package for the multi-channel delayed PWM unit: sizes, types, sequencer states.
package mcdp_pkg;
  localparam int NumChannels = 32;
  localparam int BankWidth   = 16;
  localparam int CountWidth  = 32;
  localparam int TimeWidth   = 48;
  localparam int ChanWidth   = $clog2(NumChannels);

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeEval  = 1'b1;

  // one channel's settings as held in the settings memory
  typedef struct packed {
    logic                  enable;
    logic [CountWidth-1:0] period;
    logic [CountWidth-1:0] ontime;
    logic [CountWidth-1:0] delay;
  } chan_cfg_t;

  typedef struct packed {
    logic                  mode;
    logic [4:0]            channel;
    logic                  chan_enable;
    logic [CountWidth-1:0] period_count;
    logic [CountWidth-1:0] on_count;
    logic [CountWidth-1:0] delay_count;
    logic [TimeWidth-1:0]  elapsed_count;
  } in_word_t;

  typedef struct packed {
    logic [BankWidth-1:0] low_bank;
    logic [BankWidth-1:0] high_bank;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_OUT
  } seq_state_t;
endpackage

@@ hw/rtl/mcdp_stream_if.sv @@
// Valid/ready stream interface carrying one packed word.
interface mcdp_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/mcdp_rem_unit.sv @@
// Remainder unit: restoring division, one quotient bit per cycle, one channel in flight.
module mcdp_rem_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mcdp_pkg::TimeWidth-1:0]    dividend,
  input  logic [mcdp_pkg::CountWidth-1:0]   divisor,
  output logic                              done,
  output logic [mcdp_pkg::CountWidth-1:0]   remainder
);
  import mcdp_pkg::*;
  localparam int StepWidth = $clog2(TimeWidth + 1);

  logic [TimeWidth-1:0]  quot_r, quot_nxt;
  logic [CountWidth:0]   rem_r, rem_nxt;
  logic [CountWidth-1:0] div_r;
  logic [StepWidth-1:0]  step_r, step_nxt;
  logic                  busy_r, busy_nxt;
  logic [CountWidth:0]   shifted;
  logic [CountWidth+1:0] diff;

  // shift in one dividend bit, trial subtract
  always_comb begin
    shifted  = {rem_r[CountWidth-1:0], quot_r[TimeWidth-1]};
    diff     = {1'b0, shifted} - {2'b00, div_r};
    quot_nxt = {quot_r[TimeWidth-2:0], 1'b0};
    rem_nxt  = diff[CountWidth+1] ? shifted : diff[CountWidth:0];
    step_nxt = step_r - StepWidth'(1);
    busy_nxt = busy_r && (step_r != StepWidth'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= busy_r && (step_r == StepWidth'(1));
      if (start) begin
        busy_r <= 1'b1;
      end else begin
        busy_r <= busy_nxt;
      end
    end
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
      step_r <= StepWidth'(TimeWidth);
    end else if (busy_r) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_nxt;
    end
  end

  assign remainder = rem_r[CountWidth-1:0];
endmodule

@@ hw/rtl/multi_channel_delayed_pwm_unit.sv @@
// Operation: a write word stores one channel's settings; an evaluate word, when running,
// sweeps all channels, each read from the settings memory then run through the bit-serial
// remainder unit; when not running, it gives an all-zero result word without a sweep.
// Flow: no new word is taken until the sweep is done and the result word is accepted.
// Reset: synchronous active-low; running cleared, valid bits of all channels cleared,
// so unwritten channels give a zero bit (the settings memory itself is not cleared).
module multi_channel_delayed_pwm_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  mcdp_stream_if.sink   in_s,
  mcdp_stream_if.source out_s
);
  import mcdp_pkg::*;

  // settings memory, synchronous read
  chan_cfg_t               cfg_mem [NumChannels];
  logic [NumChannels-1:0]  vld_r;
  chan_cfg_t               rd_data_r;
  logic                    rd_vld_r;

  logic                    running_r;
  seq_state_t              state_r, state_nxt;
  logic [ChanWidth-1:0]    chan_r, chan_nxt;
  logic [TimeWidth-1:0]    elapsed_r;
  logic [2*BankWidth-1:0]  bits_r;
  out_word_t               out_r;
  logic                    out_vld_r;
  logic                    rd_pend_r;
  logic                    rem_start, rem_done;
  logic [CountWidth-1:0]   rem_val;
  logic                    pass_r;
  logic [CountWidth-1:0]   ton_r;
  logic                    in_acc, last_chan, chan_bit;
  logic [TimeWidth-1:0]    diff;
  logic                    active;

  assign in_acc    = in_s.valid && in_s.ready;
  assign in_s.ready = (state_r == ST_IDLE) && !out_vld_r;
  assign last_chan = (chan_r == ChanWidth'(NumChannels-1));

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) running_r <= 1'b0;
    else if (cfg_we) running_r <= cfg_wdata;
  end

  // memory write and read; the read follows the next channel so data lines up with it
  always_ff @(posedge clk) begin
    if (in_acc && in_s.data.mode == ModeWrite &&
        32'(in_s.data.channel) < NumChannels) begin
      cfg_mem[in_s.data.channel[ChanWidth-1:0]] <= '{in_s.data.chan_enable,
        in_s.data.period_count, in_s.data.on_count, in_s.data.delay_count};
    end
    rd_data_r <= cfg_mem[chan_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (in_acc && in_s.data.mode == ModeWrite &&
                 32'(in_s.data.channel) < NumChannels) begin
      vld_r[in_s.data.channel[ChanWidth-1:0]] <= 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    chan_nxt  = chan_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_s.data.mode == ModeEval) begin
          state_nxt = running_r ? ST_SWEEP : ST_OUT;
          chan_nxt  = '0;
        end
      end
      ST_SWEEP: begin
        if (rem_done) begin
          state_nxt = last_chan ? ST_OUT : ST_SWEEP;
          chan_nxt  = chan_r + ChanWidth'(1);
        end
      end
      ST_DRAIN: state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // per-channel qualification from registered read data
  always_comb begin
    diff   = elapsed_r - TimeWidth'(rd_data_r.delay);
    active = rd_vld_r && rd_data_r.enable && (rd_data_r.period != '0) &&
             (rd_data_r.ontime != '0) && (elapsed_r >= TimeWidth'(rd_data_r.delay));
  end
  assign rem_start = rd_pend_r;
  assign chan_bit  = pass_r && (rem_val < ton_r);

  mcdp_rem_unit u_rem (
    .clk(clk), .rst_n(rst_n), .start(rem_start), .dividend(diff),
    .divisor(rd_data_r.period | CountWidth'(!active)),
    .done(rem_done), .remainder(rem_val)
  );

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      chan_r    <= '0;
      rd_pend_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chan_r    <= chan_nxt;
      // read issued on entry to a sweep and after each channel but the last completes
      rd_pend_r <= (state_r == ST_IDLE && in_acc && in_s.data.mode == ModeEval &&
                    running_r) || (state_r == ST_SWEEP && rem_done && !last_chan);
      if (state_r == ST_OUT) out_vld_r <= 1'b1;
      else if (out_s.ready) out_vld_r <= 1'b0;
    end
    rd_vld_r <= vld_r[chan_nxt];
    if (in_acc) begin
      elapsed_r <= in_s.data.elapsed_count;
      bits_r    <= '0;
    end
    if (rem_start) begin
      pass_r <= active;
      ton_r  <= rd_data_r.ontime;
    end
    if (state_r == ST_SWEEP && rem_done && 32'(chan_r) < 2*BankWidth)
      bits_r[chan_r] <= chan_bit;
    if (state_r == ST_OUT)
      out_r <= '{bits_r[BankWidth-1:0], bits_r[2*BankWidth-1:BankWidth]};
  end

  assign out_s.valid = out_vld_r;
  assign out_s.data  = out_r;
endmodule

@@ tb/sv/mcdp_checker.sv @@
// Checker for the PWM unit: tracks channel settings, predicts bank words, compares results.
module mcdp_checker
  import mcdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        fail_count,
  output int        banks_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                  run_q;
  logic                  chan_en [NumChannels];
  logic [CountWidth-1:0] chan_per[NumChannels];
  logic [CountWidth-1:0] chan_ton[NumChannels];
  logic [CountWidth-1:0] chan_dly[NumChannels];
  out_word_t             expected_banks[$];

  // one bank word for a given elapsed count from the current settings
  function automatic out_word_t predict_banks(logic [TimeWidth-1:0] elapsed);
    out_word_t  w;
    logic [63:0] phase;
    w = '0;
    if (run_q) begin
      for (int i = 0; i < NumChannels; i++) begin
        if (chan_en[i] && chan_per[i] != 0 && chan_ton[i] != 0 &&
            64'(elapsed) >= 64'(chan_dly[i])) begin
          phase = (64'(elapsed) - 64'(chan_dly[i])) % 64'(chan_per[i]);
          if (phase < 64'(chan_ton[i])) begin
            if (i < BankWidth) w.low_bank[i] = 1'b1;
            else if (i < 2 * BankWidth) w.high_bank[i - BankWidth] = 1'b1;
          end
        end
      end
    end
    return w;
  endfunction

  assign banks_pending = expected_banks.size();

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      run_q = 1'b0;
      for (int i = 0; i < NumChannels; i++) begin
        chan_en[i]  = 1'b0;
        chan_per[i] = '0;
        chan_ton[i] = '0;
        chan_dly[i] = '0;
      end
      expected_banks.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) run_q = cfg_wdata;
      // compare an accepted result word with the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_banks.size() == 0) begin
          $error("unexpected result word %h", out_data);
          fail_count++;
        end else begin
          exp_w = expected_banks.pop_front();
          if (out_data.low_bank !== exp_w.low_bank) begin
            $error("low_bank: expected %h, got %h", exp_w.low_bank, out_data.low_bank);
            fail_count++;
          end
          if (out_data.high_bank !== exp_w.high_bank) begin
            $error("high_bank: expected %h, got %h", exp_w.high_bank, out_data.high_bank);
            fail_count++;
          end
        end
      end
      // accepted input word: store settings or predict
      if (in_valid && in_ready) begin
        if (in_data.mode == ModeWrite) begin
          if (in_data.channel < NumChannels) begin
            chan_en[in_data.channel]  = in_data.chan_enable;
            chan_per[in_data.channel] = in_data.period_count;
            chan_ton[in_data.channel] = in_data.on_count;
            chan_dly[in_data.channel] = in_data.delay_count;
          end
        end else begin
          expected_banks.push_back(predict_banks(in_data.elapsed_count));
        end
      end
    end
  end
endmodule

@@ tb/sv/testbench.sv @@
// Top of the PWM unit testbench: clock, reset, stimulus and verdict.
module testbench;
  import mcdp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 12000000;
  localparam int SettleCycles = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  int   idle_in = 0;
  int   idle_out = 0;
  int   cycles = 0;
  int   fail_count;
  int   banks_pending;

  mcdp_stream_if #(.word_t(in_word_t))  in_if ();
  mcdp_stream_if #(.word_t(out_word_t)) out_if ();

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
  end

  always #5 clk = ~clk;

  multi_channel_delayed_pwm_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_s      (in_if.sink),
    .out_s     (out_if.source)
  );

  mcdp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_if.valid),
    .in_ready      (in_if.ready),
    .in_data       (in_if.data),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_data      (out_if.data),
    .fail_count    (fail_count),
    .banks_pending (banks_pending)
  );

  // receiver stalls at random
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= idle_out);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // present one word, idling first at random, and wait for its handshake
  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < idle_in) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic settings_word(int ch, bit en, logic [31:0] per, logic [31:0] ton,
                               logic [31:0] dly);
    in_word_t w;
    w = '0;
    w.mode = ModeWrite;
    w.channel = ch[4:0];
    w.chan_enable = en;
    w.period_count = per;
    w.on_count = ton;
    w.delay_count = dly;
    w.elapsed_count = TimeWidth'({$urandom, $urandom});
    send_word(w);
  endtask

  task automatic eval_word(logic [TimeWidth-1:0] el);
    in_word_t w;
    w = $bits(in_word_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
    w.mode = ModeEval;
    w.elapsed_count = el;
    send_word(w);
  endtask

  // drain all predictions, then let the block settle before a register write
  task automatic drain_and_set(bit run);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (banks_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= run;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // random words: mostly settings with small periods so edges are hit often
  task automatic random_words(int n);
    logic [31:0] per, ton, dly;
    logic [TimeWidth-1:0] el;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 75) begin
        case ($urandom_range(0, 9))
          0: per = $urandom;
          1: per = 0;
          default: per = $urandom_range(1, 64);
        endcase
        case ($urandom_range(0, 9))
          0: ton = $urandom;
          1: ton = 0;
          default: ton = $urandom_range(0, per + 1);
        endcase
        dly = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 500);
        settings_word($urandom_range(0, 31), $urandom_range(0, 7) != 0, per, ton, dly);
      end else begin
        case ($urandom_range(0, 5))
          0: el = TimeWidth'({$urandom, $urandom});
          1: el = {16'h0, $urandom};
          default: el = TimeWidth'($urandom_range(0, 1200));
        endcase
        eval_word(el);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: not running, then edges of delay, period and on-time
    settings_word(0, 1, 10, 3, 5);
    eval_word(7);
    drain_and_set(1'b1);
    eval_word(0);
    eval_word(4);
    eval_word(5);
    eval_word(7);
    eval_word(8);
    eval_word(15);
    settings_word(15, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    settings_word(16, 1, 1, 1, 32'hFFFF_FFFF);
    settings_word(31, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    settings_word(1, 1, 0, 5, 0);
    settings_word(2, 1, 5, 0, 0);
    settings_word(3, 0, 4, 2, 0);
    eval_word(48'hFFFF_FFFE);
    eval_word(48'hFFFF_FFFF);
    eval_word('1);
    eval_word(48'h1_FFFF_FFFD);
    settings_word(0, 1, 7, 9, 0);
    eval_word(6);

    idle_in = 24;
    idle_out = 63;
    random_words(500);
    drain_and_set(1'b0);
    random_words(60);
    drain_and_set(1'b1);
    idle_in = 63;
    idle_out = 24;
    random_words(500);
    idle_in = 0;
    idle_out = 0;
    random_words(470);

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (banks_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
